/* design/sttab_pkg.sv */
// Package for the software timer table: payload structs, codes and the
// command and status structs between controller and datapath. No dependencies.
package sttab_pkg;

    localparam int SLOTS_DEFAULT = 32;
    localparam int MAX_RESULTS   = 32;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SETP = 3'd1;
    localparam logic [2:0] KIND_REMS = 3'd2;
    localparam logic [2:0] KIND_REMT = 3'd3;
    localparam logic [2:0] KIND_SCAN = 3'd4;

    localparam logic [1:0] ST_ACCEPTED = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_FIRED    = 2'd2;
    localparam logic [1:0] ST_NONE     = 2'd3;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] now_ms;
        logic [4:0]  slot;
        logic [7:0]  type_code;
        logic [31:0] period_ms;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [4:0] slot_out;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic srch;
        logic alloc;
        logic exec;
        logic walk;
        logic res_push;
        logic end_push;
    } sttab_cmd_t;

    typedef struct packed {
        logic srch_done;
        logic walk_end;
        logic out_free;
        logic scan_mode;
    } sttab_sts_t;

endpackage

/* design/sttab_ctrl.sv */
// Controller state machine of the software timer table.
// Depends on sttab_pkg for the command and status structs and kind codes.
module sttab_ctrl
    import sttab_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_kind,
    input  sttab_sts_t sts,
    output sttab_cmd_t cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SRCH = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_RESP = 3'd4;
    localparam logic [2:0] S_END  = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.load = 1'b1;
                    case (s_kind)
                        KIND_ADD:  state_next = S_SRCH;
                        KIND_SETP: state_next = S_EXEC;
                        KIND_REMS: state_next = S_EXEC;
                        KIND_REMT: state_next = S_WALK;
                        KIND_SCAN: state_next = S_WALK;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_SRCH: begin
                cmd.srch = 1'b1;
                if (sts.srch_done) begin
                    cmd.alloc  = 1'b1;
                    state_next = S_RESP;
                end
            end
            S_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = S_RESP;
            end
            S_WALK: begin
                cmd.walk = 1'b1;
                if (sts.walk_end) begin
                    state_next = sts.scan_mode ? S_END : S_RESP;
                end
            end
            S_RESP: begin
                if (sts.out_free) begin
                    cmd.res_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_END: begin
                if (sts.out_free) begin
                    cmd.end_push = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/sttab_dp.sv */
// Datapath of the software timer table: slot memories, active bits, walk
// pipeline and output register. Depends on sttab_pkg.
module sttab_dp
    import sttab_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  in_item_t   s_item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata,
    input  sttab_cmd_t cmd,
    output sttab_sts_t sts,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item
);

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IW = $clog2(SLOTS + 1);
    localparam int CW = $clog2(MAX_RESULTS + 1);

    logic [31:0] period_mem [SLOTS];
    logic [31:0] last_mem   [SLOTS];
    logic [7:0]  type_mem   [SLOTS];

    in_item_t        item_reg;
    logic [7:0]      once_reg;
    logic [SLOTS-1:0] active_reg, active_next;
    logic [IW-1:0]   hw_reg, hw_next;
    logic [IW-1:0]   idx_reg, idx_next;
    logic            ev_vld_reg, ev_vld_next;
    logic [AW-1:0]   ev_idx_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            pend_vld_reg, pend_vld_next;
    logic [AW-1:0]   pend_slot_reg;
    logic [1:0]      res_status_reg;
    logic [4:0]      res_slot_reg;
    logic            m_valid_reg, m_valid_next;
    out_item_t       m_item_reg, m_item_next;
    logic [31:0]     period_rd_reg;
    logic [31:0]     last_rd_reg;
    logic [7:0]      type_rd_reg;

    logic          issue_ok;
    logic          cur_active;
    logic          full_cnt;
    logic          is_scan;
    logic [31:0]   diff;
    logic          fire;
    logic          out_free;
    logic          step;
    logic          add_full;
    logic          alloc_now;
    logic          slot_ok;
    logic [AW-1:0] idx_a;
    logic [AW-1:0] slot_a;
    logic          period_we;
    logic [AW-1:0] period_wa;
    logic          last_we;
    logic [AW-1:0] last_wa;
    logic [31:0]   last_wd;
    logic          push;

    assign idx_a      = idx_reg[AW-1:0];
    assign slot_a     = AW'(item_reg.slot);
    assign issue_ok   = idx_reg < hw_reg;
    assign cur_active = active_reg[idx_a];
    assign full_cnt   = cnt_reg == CW'(MAX_RESULTS);
    assign is_scan    = item_reg.kind == KIND_SCAN;
    assign diff       = item_reg.now_ms - last_rd_reg;
    assign fire       = is_scan && ev_vld_reg && !full_cnt && active_reg[ev_idx_reg]
                        && (diff > period_rd_reg);
    assign out_free   = !m_valid_reg || m_ready;
    assign step       = cmd.walk && !(fire && pend_vld_reg && !out_free);
    assign add_full   = idx_reg == IW'(SLOTS);
    assign alloc_now  = cmd.alloc && !add_full;
    assign slot_ok    = 7'(item_reg.slot) < 7'(SLOTS);

    assign sts.srch_done = !(issue_ok && cur_active);
    assign sts.walk_end  = (!ev_vld_reg && !issue_ok) || full_cnt;
    assign sts.out_free  = out_free;
    assign sts.scan_mode = is_scan;

    assign period_we = alloc_now || (cmd.exec && item_reg.kind == KIND_SETP && slot_ok);
    assign period_wa = alloc_now ? idx_a : slot_a;
    assign last_we   = alloc_now || (step && fire);
    assign last_wa   = alloc_now ? idx_a : ev_idx_reg;
    assign last_wd   = alloc_now ? item_reg.now_ms : (last_rd_reg + period_rd_reg);

    always_ff @(posedge aclk) begin
        if (period_we) begin
            period_mem[period_wa] <= item_reg.period_ms;
        end
        if (last_we) begin
            last_mem[last_wa] <= last_wd;
        end
        if (alloc_now) begin
            type_mem[idx_a] <= item_reg.type_code;
        end
        if (step) begin
            period_rd_reg <= period_mem[idx_a];
            last_rd_reg   <= last_mem[idx_a];
            type_rd_reg   <= type_mem[idx_a];
        end
    end

    always_comb begin
        active_next   = active_reg;
        hw_next       = hw_reg;
        idx_next      = idx_reg;
        ev_vld_next   = ev_vld_reg;
        cnt_next      = cnt_reg;
        pend_vld_next = pend_vld_reg;
        if (alloc_now) begin
            active_next[idx_a] = 1'b1;
            if (idx_reg == hw_reg) begin
                hw_next = hw_reg + IW'(1);
            end
        end
        if (cmd.exec && item_reg.kind == KIND_REMS && slot_ok) begin
            active_next[slot_a] = 1'b0;
        end
        if (step && fire) begin
            cnt_next      = cnt_reg + CW'(1);
            pend_vld_next = 1'b1;
            if (type_rd_reg == once_reg) begin
                active_next[ev_idx_reg] = 1'b0;
            end
        end
        if (step && !is_scan && ev_vld_reg && type_rd_reg == item_reg.type_code) begin
            active_next[ev_idx_reg] = 1'b0;
        end
        if (cmd.srch && !sts.srch_done) begin
            idx_next = idx_reg + IW'(1);
        end
        if (step) begin
            ev_vld_next = issue_ok;
            if (issue_ok) begin
                idx_next = idx_reg + IW'(1);
            end
        end
        if (cmd.load) begin
            idx_next      = '0;
            ev_vld_next   = 1'b0;
            cnt_next      = '0;
            pend_vld_next = 1'b0;
        end
    end

    always_comb begin
        push        = 1'b0;
        m_item_next = m_item_reg;
        if (cmd.res_push) begin
            push        = 1'b1;
            m_item_next = '{status: res_status_reg, slot_out: res_slot_reg, last_of_run: 1'b1};
        end else if (cmd.end_push) begin
            push = 1'b1;
            if (pend_vld_reg) begin
                m_item_next = '{status: ST_FIRED, slot_out: 5'(pend_slot_reg),
                                last_of_run: 1'b1};
            end else begin
                m_item_next = '{status: ST_NONE, slot_out: 5'd0, last_of_run: 1'b1};
            end
        end else if (step && fire && pend_vld_reg) begin
            push        = 1'b1;
            m_item_next = '{status: ST_FIRED, slot_out: 5'(pend_slot_reg), last_of_run: 1'b0};
        end
        if (push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            item_reg       <= s_item;
            res_status_reg <= ST_ACCEPTED;
            res_slot_reg   <= (s_item.kind == KIND_REMT) ? 5'd0 : s_item.slot;
        end else if (cmd.alloc) begin
            res_status_reg <= add_full ? ST_FULL : ST_ACCEPTED;
            res_slot_reg   <= add_full ? 5'd0 : 5'(idx_reg);
        end
        if (step) begin
            ev_idx_reg <= idx_a;
        end
        if (step && fire) begin
            pend_slot_reg <= ev_idx_reg;
        end
        m_item_reg <= m_item_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            once_reg     <= '0;
            active_reg   <= '0;
            hw_reg       <= '0;
            idx_reg      <= '0;
            ev_vld_reg   <= 1'b0;
            cnt_reg      <= '0;
            pend_vld_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                once_reg <= cfg_wdata;
            end
            active_reg   <= active_next;
            hw_reg       <= hw_next;
            idx_reg      <= idx_next;
            ev_vld_reg   <= ev_vld_next;
            cnt_reg      <= cnt_next;
            pend_vld_reg <= pend_vld_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

/* design/software_timer_table_top.sv */
// Channel    Direction  Transaction
// s_         in         one command: add, set period, remove, remove by type, scan
// m_         out        one result: status, slot, last-of-run flag
// cfg_       in         write of the one-shot type code, no handshake
//
// One command is taken at a time. Set period and remove slot need no walk;
// add walks the active bits before it allocates a slot. Remove by type
// and scan walk the slots below the high-water mark through the slot memories,
// one slot a cycle while the result port does not hold the scan; a scan also
// ends once MAX_RESULTS slots have fired. Reset is synchronous and clears the
// active bits and the mark; the slot memories are not cleared.
// A stalled result port holds the scan walk until the waiting result is taken.
//
// Top level of the software timer table. Depends on sttab_pkg, sttab_ctrl
// and sttab_dp.
module software_timer_table_top
    import sttab_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  in_item_t   s_item,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_item,
    input  logic       cfg_we,
    input  logic [7:0] cfg_wdata
);

    sttab_cmd_t cmd;
    sttab_sts_t sts;

    sttab_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_item.kind),
        .sts     (sts),
        .cmd     (cmd)
    );

    sttab_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_item    (s_item),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule

/* tb/sv/timer_table_checker.sv */
`timescale 1ns / 100ps
// Checker for the software timer table: keeps its own copy of the slot table,
// predicts the results of every accepted command and compares each result
// transaction in order. Depends on sttab_pkg.
module timer_table_checker
    import sttab_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  in_item_t    s_item,
    input  logic        m_valid,
    input  logic        m_ready,
    input  out_item_t   m_item,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    output int unsigned error_count,
    output int unsigned results_due
);

    logic        slot_live   [SLOTS];
    logic [31:0] slot_period [SLOTS];
    logic [31:0] slot_stamp  [SLOTS];
    logic [7:0]  slot_type   [SLOTS];
    int unsigned mark;
    logic [7:0]  once_code;
    out_item_t   expected_results [$];

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, what, got, want);
        error_count++;
    endtask

    function automatic void expect_result(input logic [1:0] status, input logic [4:0] slot,
                                          input logic last);
        out_item_t res;
        res.status      = status;
        res.slot_out    = slot;
        res.last_of_run = last;
        expected_results.push_back(res);
    endfunction

    function automatic void predict_command(input in_item_t cmd);
        int unsigned idx;
        int unsigned fired;
        logic [31:0] age;
        out_item_t   tail;
        case (cmd.kind)
            KIND_ADD: begin
                idx = 0;
                while (idx < mark && slot_live[idx]) idx++;
                if (idx >= SLOTS) begin
                    expect_result(ST_FULL, '0, 1'b1);
                end else begin
                    slot_live[idx]   = 1'b1;
                    slot_period[idx] = cmd.period_ms;
                    slot_type[idx]   = cmd.type_code;
                    slot_stamp[idx]  = cmd.now_ms;
                    if (idx == mark) mark++;
                    expect_result(ST_ACCEPTED, idx[4:0], 1'b1);
                end
            end
            KIND_SETP: begin
                if (cmd.slot < SLOTS) slot_period[cmd.slot] = cmd.period_ms;
                expect_result(ST_ACCEPTED, cmd.slot, 1'b1);
            end
            KIND_REMS: begin
                if (cmd.slot < SLOTS) slot_live[cmd.slot] = 1'b0;
                expect_result(ST_ACCEPTED, cmd.slot, 1'b1);
            end
            KIND_REMT: begin
                for (idx = 0; idx < mark; idx++) begin
                    if (slot_type[idx] == cmd.type_code) slot_live[idx] = 1'b0;
                end
                expect_result(ST_ACCEPTED, '0, 1'b1);
            end
            KIND_SCAN: begin
                fired = 0;
                for (idx = 0; idx < mark && fired < MAX_RESULTS; idx++) begin
                    if (slot_live[idx]) begin
                        age = cmd.now_ms - slot_stamp[idx];
                        if (age > slot_period[idx]) begin
                            slot_stamp[idx] = slot_stamp[idx] + slot_period[idx];
                            if (slot_type[idx] == once_code) slot_live[idx] = 1'b0;
                            expect_result(ST_FIRED, idx[4:0], 1'b0);
                            fired++;
                        end
                    end
                end
                if (fired == 0) begin
                    expect_result(ST_NONE, '0, 1'b1);
                end else begin
                    tail = expected_results.pop_back();
                    tail.last_of_run = 1'b1;
                    expected_results.push_back(tail);
                end
            end
            default: begin
            end
        endcase
    endfunction

    always @(posedge aclk) begin : watch
        out_item_t want;
        if (!aresetn) begin
            foreach (slot_live[i]) slot_live[i] = 1'b0;
            mark        = 0;
            once_code   = '0;
            error_count = 0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result transaction with none expected",
                                    32'(m_item), 32'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.status !== want.status)
                        report_mismatch("status", 32'(m_item.status), 32'(want.status));
                    if (m_item.slot_out !== want.slot_out)
                        report_mismatch("slot_out", 32'(m_item.slot_out),
                                        32'(want.slot_out));
                    if (m_item.last_of_run !== want.last_of_run)
                        report_mismatch("last_of_run", 32'(m_item.last_of_run),
                                        32'(want.last_of_run));
                end
            end
            if (s_valid && s_ready) predict_command(s_item);
            if (cfg_we) once_code = cfg_wdata;
        end
        results_due = expected_results.size();
    end

endmodule

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// Top of the software timer table testbench: clock, reset, command stimulus,
// result back-pressure and the verdict. Depends on sttab_pkg,
// software_timer_table_top and timer_table_checker.
module testbench
    import sttab_pkg::*;
();

    localparam int          SLOTS         = SLOTS_DEFAULT;
    localparam int          CLK_PERIOD    = 10;
    localparam int          RESET_CYCLES  = 5;
    localparam int          SETTLE_CYCLES = SLOTS + 16;
    localparam int          HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam logic [2:0]  KIND_LAST     = 3'd7;

    typedef enum {MODE_MIX, MODE_FILL, MODE_NOISE} run_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_item;
    logic        m_valid;
    logic        m_ready;
    out_item_t   m_item;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    int unsigned error_count;
    int unsigned results_due;
    int unsigned cycle_count;
    int unsigned tx_sent;
    logic        tx_steady;
    logic [31:0] clock_ms;

    software_timer_table_top #(.SLOTS(SLOTS)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    timer_table_checker #(.SLOTS(SLOTS)) result_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_item     (m_item),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .error_count(error_count),
        .results_due(results_due)
    );

    initial aclk = 1'b0;
    always #(CLK_PERIOD / 2) aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic in_item_t make_cmd(input logic [2:0] kind, input logic [31:0] now,
                                          input logic [4:0] slot, input logic [7:0] type_code,
                                          input logic [31:0] period);
        in_item_t cmd;
        cmd.kind      = kind;
        cmd.now_ms    = now;
        cmd.slot      = slot;
        cmd.type_code = type_code;
        cmd.period_ms = period;
        return cmd;
    endfunction

    function automatic in_item_t random_command(input run_mode_t mode);
        in_item_t    cmd;
        int unsigned pick;
        int unsigned spread;
        pick   = $urandom_range(0, 99);
        spread = $urandom_range(0, 9);
        cmd.slot = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 7))
                                               : 5'($urandom_range(0, 31));
        cmd.type_code = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                    : 8'($urandom_range(0, 3));
        if (spread < 7)      cmd.period_ms = $urandom_range(0, 12);
        else if (spread < 9) cmd.period_ms = $urandom_range(0, 200);
        else                 cmd.period_ms = $urandom;
        if (mode == MODE_NOISE) begin
            cmd.kind      = 3'($urandom_range(0, 7));
            cmd.now_ms    = $urandom;
            cmd.slot      = 5'($urandom);
            cmd.type_code = 8'($urandom);
            cmd.period_ms = $urandom;
            return cmd;
        end
        if (mode == MODE_FILL) begin
            cmd.kind = (pick < 85) ? KIND_ADD : KIND_SCAN;
        end else begin
            if (pick < 40)      cmd.kind = KIND_ADD;
            else if (pick < 50) cmd.kind = KIND_SETP;
            else if (pick < 60) cmd.kind = KIND_REMS;
            else if (pick < 67) cmd.kind = KIND_REMT;
            else if (pick < 97) cmd.kind = KIND_SCAN;
            else                cmd.kind = 3'($urandom_range(KIND_SCAN + 1, KIND_LAST));
        end
        if (cmd.kind == KIND_SCAN) begin
            if ($urandom_range(0, 19) == 0) clock_ms = clock_ms + $urandom;
            else                            clock_ms = clock_ms + $urandom_range(0, 6);
        end
        cmd.now_ms = clock_ms;
        return cmd;
    endfunction

    task automatic send_command(input in_item_t cmd);
        int unsigned gap;
        if (tx_sent % 25 == 0) tx_steady = ($urandom_range(0, 2) == 0);
        tx_sent++;
        gap = tx_steady ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= cmd;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        while (results_due != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_once_code(input logic [7:0] code);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    initial begin : result_sink
        int unsigned rx_wait;
        int unsigned taken;
        logic        rx_steady;
        rx_wait   = 0;
        taken     = 0;
        rx_steady = 1'b0;
        m_ready   = 1'b0;
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                taken++;
                if (taken % 30 == 0) rx_steady = ($urandom_range(0, 2) == 0);
                if (taken == 40 || taken == 250) rx_wait = HOLD_CYCLES;
                else rx_wait = rx_steady ? 0 : $urandom_range(0, 9);
            end
            @(negedge aclk);
            if (rx_wait > 0) begin
                m_ready <= 1'b0;
                rx_wait--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        run_mode_t   mode;
        logic [7:0]  code;
        int unsigned count;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_item    = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        tx_sent   = 0;
        tx_steady = 1'b0;
        clock_ms  = '0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        write_once_code(8'h00);
        send_command(make_cmd(KIND_SCAN, 32'd0, 5'd0, 8'd0, 32'd0));
        send_command(make_cmd(KIND_ADD, 32'd0, 5'd0, 8'h00, 32'd0));
        send_command(make_cmd(KIND_ADD, 32'hFFFF_FFFF, 5'd31, 8'hFF, 32'hFFFF_FFFF));
        send_command(make_cmd(KIND_ADD, 32'd100, 5'd0, 8'd1, 32'd5));
        send_command(make_cmd(KIND_SETP, 32'd0, 5'd31, 8'd0, 32'd7));
        send_command(make_cmd(KIND_SETP, 32'd0, 5'd2, 8'd0, 32'd3));
        send_command(make_cmd(KIND_SCAN, 32'd1, 5'd0, 8'd0, 32'd0));
        send_command(make_cmd(KIND_SCAN, 32'd1, 5'd0, 8'd0, 32'd0));
        for (int k = KIND_SCAN + 1; k <= KIND_LAST; k++)
            send_command(make_cmd(3'(k), $urandom, 5'($urandom), 8'($urandom), $urandom));
        send_command(make_cmd(KIND_ADD, 32'd200, 5'd0, 8'd2, 32'd10));
        send_command(make_cmd(KIND_REMS, 32'd0, 5'd1, 8'd0, 32'd0));
        send_command(make_cmd(KIND_REMS, 32'd0, 5'd0, 8'd0, 32'd0));
        send_command(make_cmd(KIND_REMT, 32'd0, 5'd0, 8'd1, 32'd0));
        send_command(make_cmd(KIND_REMT, 32'd0, 5'd0, 8'd99, 32'd0));
        send_command(make_cmd(KIND_SCAN, 32'd500, 5'd0, 8'd0, 32'd0));
        send_command(make_cmd(KIND_REMS, 32'd0, 5'd31, 8'd0, 32'd0));
        send_command(make_cmd(KIND_ADD, 32'd600, 5'd0, 8'd3, 32'd1));
        send_command(make_cmd(KIND_REMS, 32'd0, 5'd0, 8'd0, 32'd0));

        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0: begin code = 8'd1;             mode = MODE_MIX;   count = 50; end
                1: begin code = 8'hFF;            mode = MODE_FILL;  count = 60; end
                2: begin code = 8'd0;             mode = MODE_MIX;   count = 60; end
                3: begin code = 8'($urandom);     mode = MODE_NOISE; count = 30; end
                4: begin code = 8'd2;             mode = MODE_MIX;   count = 50; end
                default: begin code = 8'd3;       mode = MODE_MIX;   count = 50; end
            endcase
            write_once_code(code);
            clock_ms = $urandom;
            repeat (count) send_command(random_command(mode));
        end

        wait_idle();
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
